[hdl/deadline_timer_table_unit_assert.svh]
// assertion macros for the deadline timer table
`ifndef DEADLINE_TIMER_TABLE_UNIT_ASSERT_SVH
`define DEADLINE_TIMER_TABLE_UNIT_ASSERT_SVH

// same-cycle implication, quiet while reset is high
`define DTT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet while reset is high
`define DTT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/dtt_pkg.sv]
// shared types and constants of the deadline timer table
`timescale 1ns / 1ps

package dtt_pkg;

   localparam int KIND_W    = 2;
   localparam int ID_W      = 4;
   localparam int TIMEOUT_W = 32;
   localparam int DATA_W    = 32;
   localparam int TIME_W    = 48;
   localparam int STATUS_W  = 3;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_REGISTER = 2'd0;
   localparam logic [KIND_W-1:0] KIND_UPDATE   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TICK     = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      STAT_REGISTERED = 3'd0,
      STAT_FULL       = 3'd1,
      STAT_UPDATED    = 3'd2,
      STAT_MISSING    = 3'd3,
      STAT_TICK       = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_DONE,
      S_FIRE_SEEK,
      S_FIRE_OUT
   } state_type;

   // one slot arriving from the deadline memory during a scan
   typedef struct packed {
      logic valid;
      logic live;
      logic first;
   } scan_step_type;

   // memory port strobes
   typedef struct packed {
      logic dl_wr;
      logic pl_wr;
      logic dl_rd;
      logic pl_rd;
   } mem_ctl_type;

endpackage

[hdl/dtt_ifs.sv]
// request and response channel interfaces of the deadline timer table
`timescale 1ns / 1ps

interface dtt_req_if;
   logic                         valid;
   logic                         ready;
   logic [dtt_pkg::KIND_W-1:0]    kind;
   logic [dtt_pkg::ID_W-1:0]      timer_id;
   logic [dtt_pkg::TIMEOUT_W-1:0] timeout;
   logic [dtt_pkg::DATA_W-1:0]    user_data;

   modport source (output valid, kind, timer_id, timeout, user_data, input ready);
   modport sink   (input valid, kind, timer_id, timeout, user_data, output ready);
endinterface

interface dtt_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [dtt_pkg::STATUS_W-1:0] status;
   logic                        fired;
   logic [dtt_pkg::ID_W-1:0]     result_id;
   logic [dtt_pkg::DATA_W-1:0]   fired_data;
   logic [dtt_pkg::TIME_W-1:0]   earliest_deadline;
   logic                        last;

   modport source (output valid, status, fired, result_id, fired_data, earliest_deadline, last,
                   input ready);
   modport sink   (input valid, status, fired, result_id, fired_data, earliest_deadline, last,
                   output ready);
endinterface

[hdl/deadline_timer_table_unit.sv]
// deadline timer table top level: control fsm, live bits, tick counter, result register
// requests are taken only in idle; the scan reads one slot per cycle, a drain state folds in
// the last slot and the done state loads the result register; a firing tick then walks slot
// by slot up to each fired id, fetches its user word and emits one beat per fire; a result
// beat held by the sink stalls the done and fire states; no new item is taken until idle
// reset: synchronous, clears tick counter, live bits and fsm; memories are not cleared
`timescale 1ns / 1ps

module deadline_timer_table_unit #(
   parameter int NUM_TIMERS = 16
) (
   input  logic      clock,
   input  logic      reset,
   dtt_req_if.sink   req_bus,
   dtt_rsp_if.source rsp_bus
);
   import dtt_pkg::*;

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

   // control state
   state_type             state_ff, state_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic [NUM_TIMERS-1:0] live_ff, live_in;
   logic [NUM_TIMERS-1:0] fire_ff, fire_in;
   logic [IDX_W-1:0]      rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]      seek_ff, seek_in;
   logic                  step_valid_ff, step_valid_in;
   logic                  step_first_ff, step_first_in;
   logic [IDX_W-1:0]      step_idx_ff, step_idx_in;

   // captured request
   logic [KIND_W-1:0]     kind_ff, kind_in;
   logic [ID_W-1:0]       tid_ff, tid_in;
   logic [TIME_W-1:0]     newdl_ff, newdl_in;
   logic [DATA_W-1:0]     data_ff, data_in;
   logic                  upd_ok_ff, upd_ok_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff;
   logic                  rsp_fired_ff;
   logic [ID_W-1:0]       rsp_id_ff;
   logic [DATA_W-1:0]     rsp_data_ff;
   logic [TIME_W-1:0]     rsp_dl_ff;
   logic                  rsp_last_ff;

   // result load
   logic                  out_load;
   logic                  out_free;
   status_type            out_status;
   logic                  out_fired;
   logic [ID_W-1:0]       out_id;
   logic [DATA_W-1:0]     out_data;
   logic [TIME_W-1:0]     out_dl;
   logic                  out_last;

   // memory side
   mem_ctl_type           mem_ctl;
   logic [IDX_W-1:0]      wr_addr;
   logic [TIME_W-1:0]     wr_deadline;
   logic [IDX_W-1:0]      pl_rd_addr;
   logic [TIME_W-1:0]     rd_deadline;
   logic [DATA_W-1:0]     rd_payload;

   // scan helpers
   scan_step_type         step_cur;
   logic                  expire;
   logic                  min_any;
   logic [TIME_W-1:0]     min_deadline;
   logic [TIME_W-1:0]     earliest;
   logic [IDX_W-1:0]      pick_id;
   logic                  pick_full;
   logic                  accept;
   logic [IDX_W-1:0]      tid_idx;
   logic                  tid_in_range;
   logic [TIME_W-1:0]     arm_sum;
   logic [NUM_TIMERS-1:0] fire_left;

   // check terms
   logic                  rsp_nontick;
   logic                  fire_report;

   // deadline and payload storage
   dtt_store #(
      .NUM_TIMERS (NUM_TIMERS),
      .IDX_W      (IDX_W)
   ) u_store (
      .clock       (clock),
      .ctl         (mem_ctl),
      .wr_addr     (wr_addr),
      .wr_deadline (wr_deadline),
      .wr_payload  (data_ff),
      .dl_rd_addr  (rd_idx_ff),
      .pl_rd_addr  (pl_rd_addr),
      .rd_deadline (rd_deadline),
      .rd_payload  (rd_payload)
   );

   // slot presented this cycle: memory data lines up with the registered index
   assign step_cur = '{valid: step_valid_ff, live: live_ff[step_idx_ff], first: step_first_ff};

   dtt_minscan u_minscan (
      .clock        (clock),
      .reset        (reset),
      .step         (step_cur),
      .tick_mode    (kind_ff == KIND_TICK),
      .now          (now_ff),
      .rd_deadline  (rd_deadline),
      .expire       (expire),
      .min_any      (min_any),
      .min_deadline (min_deadline)
   );

   dtt_idpick #(
      .IDX_W (IDX_W)
   ) u_idpick (
      .clock     (clock),
      .reset     (reset),
      .step      (step_cur),
      .step_idx  (step_idx_ff),
      .pick_id   (pick_id),
      .pick_full (pick_full)
   );

   // request side is free whenever the fsm is idle, even with a result still held
   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign tid_idx       = IDX_W'(req_bus.timer_id);
   assign tid_in_range  = int'(req_bus.timer_id) < NUM_TIMERS;
   assign arm_sum       = now_ff + TIME_W'(req_bus.timeout);
   assign earliest      = min_any ? min_deadline : '0;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign fire_left     = fire_ff & ~(NUM_TIMERS'(1) << seek_ff);

   always_comb begin
      state_in      = state_ff;
      now_in        = now_ff;
      live_in       = live_ff;
      fire_in       = fire_ff;
      rd_idx_in     = rd_idx_ff;
      seek_in       = seek_ff;
      step_valid_in = 1'b0;
      step_first_in = 1'b0;
      step_idx_in   = step_idx_ff;
      kind_in       = kind_ff;
      tid_in        = tid_ff;
      newdl_in      = newdl_ff;
      data_in       = data_ff;
      upd_ok_in     = upd_ok_ff;
      mem_ctl       = '0;
      wr_addr       = tid_idx;
      wr_deadline   = arm_sum;
      pl_rd_addr    = seek_ff;
      out_load      = 1'b0;
      out_status    = STAT_TICK;
      out_fired     = 1'b0;
      out_id        = '0;
      out_data      = '0;
      out_dl        = earliest;
      out_last      = 1'b1;

      // expired slots leave the live set and join the fire mask as the scan passes
      if (expire) begin
         live_in[step_idx_ff] = 1'b0;
         fire_in[step_idx_ff] = 1'b1;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               kind_in   = req_bus.kind;
               tid_in    = req_bus.timer_id;
               data_in   = req_bus.user_data;
               newdl_in  = arm_sum;
               rd_idx_in = '0;
               unique case (req_bus.kind)
                  KIND_REGISTER: begin
                     state_in = S_SCAN;
                  end
                  KIND_UPDATE: begin
                     // re-arm goes straight to memory, the scan then sees the new deadline
                     upd_ok_in     = tid_in_range && live_ff[tid_idx];
                     mem_ctl.dl_wr = tid_in_range && live_ff[tid_idx];
                     state_in      = S_SCAN;
                  end
                  KIND_TICK: begin
                     now_in   = now_ff + TIME_W'(1);
                     state_in = S_SCAN;
                  end
                  default: begin
                     // unused kind: dropped without a result
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            mem_ctl.dl_rd = 1'b1;
            step_valid_in = 1'b1;
            step_idx_in   = rd_idx_ff;
            step_first_in = (rd_idx_ff == '0);
            rd_idx_in     = rd_idx_ff + IDX_W'(1);
            if (rd_idx_ff == LAST_IDX) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // last slot is being folded into the trackers
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               priority if (kind_ff == KIND_REGISTER) begin
                  out_load = 1'b1;
                  state_in = S_IDLE;
                  if (pick_full) begin
                     out_status = STAT_FULL;
                  end else begin
                     mem_ctl.dl_wr    = 1'b1;
                     mem_ctl.pl_wr    = 1'b1;
                     wr_addr          = pick_id;
                     wr_deadline      = newdl_ff;
                     live_in[pick_id] = 1'b1;
                     out_status       = STAT_REGISTERED;
                     out_id           = ID_W'(pick_id);
                     out_dl           = (!min_any || (newdl_ff < min_deadline)) ?
                                        newdl_ff : min_deadline;
                  end
               end else if (kind_ff == KIND_UPDATE) begin
                  out_load   = 1'b1;
                  out_status = upd_ok_ff ? STAT_UPDATED : STAT_MISSING;
                  out_id     = tid_ff;
                  state_in   = S_IDLE;
               end else begin
                  if (fire_ff == '0) begin
                     // quiet tick
                     out_load = 1'b1;
                     state_in = S_IDLE;
                  end else begin
                     seek_in  = '0;
                     state_in = S_FIRE_SEEK;
                  end
               end
            end
         end
         S_FIRE_SEEK: begin
            // walk up to the next fired slot, then fetch its user word
            if (fire_ff[seek_ff]) begin
               mem_ctl.pl_rd = 1'b1;
               state_in      = S_FIRE_OUT;
            end else begin
               seek_in = seek_ff + IDX_W'(1);
            end
         end
         S_FIRE_OUT: begin
            if (out_free) begin
               out_load  = 1'b1;
               out_fired = 1'b1;
               out_id    = ID_W'(seek_ff);
               out_data  = rd_payload;
               out_last  = (fire_left == '0);
               fire_in   = fire_left;
               seek_in   = seek_ff + IDX_W'(1);
               state_in  = (fire_left == '0) ? S_IDLE : S_FIRE_SEEK;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         now_ff        <= '0;
         live_ff       <= '0;
         fire_ff       <= '0;
         rd_idx_ff     <= '0;
         seek_ff       <= '0;
         step_valid_ff <= 1'b0;
         step_first_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         now_ff        <= now_in;
         live_ff       <= live_in;
         fire_ff       <= fire_in;
         rd_idx_ff     <= rd_idx_in;
         seek_ff       <= seek_in;
         step_valid_ff <= step_valid_in;
         step_first_ff <= step_first_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      step_idx_ff <= step_idx_in;
      kind_ff     <= kind_in;
      tid_ff      <= tid_in;
      newdl_ff    <= newdl_in;
      data_ff     <= data_in;
      upd_ok_ff   <= upd_ok_in;
      if (out_load) begin
         rsp_status_ff <= out_status;
         rsp_fired_ff  <= out_fired;
         rsp_id_ff     <= out_id;
         rsp_data_ff   <= out_data;
         rsp_dl_ff     <= out_dl;
         rsp_last_ff   <= out_last;
      end
   end

   // result beat
   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.status            = rsp_status_ff;
   assign rsp_bus.fired             = rsp_fired_ff;
   assign rsp_bus.result_id         = rsp_id_ff;
   assign rsp_bus.fired_data        = rsp_data_ff;
   assign rsp_bus.earliest_deadline = rsp_dl_ff;
   assign rsp_bus.last              = rsp_last_ff;

   assign rsp_nontick = rsp_bus.valid && (rsp_bus.status != STAT_TICK);
   assign fire_report = (state_ff == S_FIRE_OUT) && out_free;

`include "deadline_timer_table_unit_assert.svh"

   // anything but a tick answers with exactly one beat
   `DTT_ASSERT_NOW(a_single_beat, rsp_nontick, rsp_bus.last, "non-tick result without last")
   // the seek walk only runs while fired slots remain
   `DTT_ASSERT_NOW(a_seek_pending, state_ff == S_FIRE_SEEK, fire_ff != '0, "empty fire walk")
   // every fired slot is reported before the next item is taken
   `DTT_ASSERT_NOW(a_idle_clean, state_ff == S_IDLE, fire_ff == '0, "unreported fires")
   // a fired report clears its slot from the pending mask
   `DTT_ASSERT_NEXT(a_fire_cleared, fire_report, !fire_ff[$past(seek_ff)], "slot still pending")

endmodule

[hdl/dtt_store.sv]
// deadline and payload memories, one write port and one registered read port each
`timescale 1ns / 1ps

module dtt_store #(
   parameter int NUM_TIMERS = 16,
   parameter int IDX_W      = 4
) (
   input  logic                       clock,
   input  dtt_pkg::mem_ctl_type       ctl,
   input  logic [IDX_W-1:0]           wr_addr,
   input  logic [dtt_pkg::TIME_W-1:0] wr_deadline,
   input  logic [dtt_pkg::DATA_W-1:0] wr_payload,
   input  logic [IDX_W-1:0]           dl_rd_addr,
   input  logic [IDX_W-1:0]           pl_rd_addr,
   output logic [dtt_pkg::TIME_W-1:0] rd_deadline,
   output logic [dtt_pkg::DATA_W-1:0] rd_payload
);
   import dtt_pkg::*;

   logic [TIME_W-1:0] deadline_mem [NUM_TIMERS];
   logic [DATA_W-1:0] payload_mem  [NUM_TIMERS];
   logic [TIME_W-1:0] rd_deadline_ff;
   logic [DATA_W-1:0] rd_payload_ff;

   always_ff @(posedge clock) begin
      if (ctl.dl_wr) begin
         deadline_mem[wr_addr] <= wr_deadline;
      end
      if (ctl.pl_wr) begin
         payload_mem[wr_addr] <= wr_payload;
      end
      if (ctl.dl_rd) begin
         rd_deadline_ff <= deadline_mem[dl_rd_addr];
      end
      if (ctl.pl_rd) begin
         rd_payload_ff <= payload_mem[pl_rd_addr];
      end
   end

   assign rd_deadline = rd_deadline_ff;
   assign rd_payload  = rd_payload_ff;

endmodule

[hdl/dtt_idpick.sv]
// id allocator: follows the live bits slot by slot during a scan
`timescale 1ns / 1ps

module dtt_idpick #(
   parameter int IDX_W = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dtt_pkg::scan_step_type step,
   input  logic [IDX_W-1:0]       step_idx,
   output logic [IDX_W-1:0]       pick_id,
   output logic                   pick_full
);
   import dtt_pkg::*;

   logic             lo_ff, lo_in;
   logic             run_ff, run_in;
   logic             cand_found_ff, cand_found_in;
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] cand_ff, cand_in;
   logic [IDX_W-1:0] free_ff, free_in;
   logic             b_lo, b_run, b_cand, b_free;

   always_comb begin
      b_lo   = step.first ? 1'b0 : lo_ff;
      b_run  = step.first ? 1'b0 : run_ff;
      b_cand = step.first ? 1'b0 : cand_found_ff;
      b_free = step.first ? 1'b0 : free_found_ff;
      lo_in         = lo_ff;
      run_in        = run_ff;
      cand_found_in = cand_found_ff;
      free_found_in = free_found_ff;
      cand_in       = cand_ff;
      free_in       = free_ff;
      if (step.valid) begin
         lo_in         = b_lo;
         run_in        = b_run;
         cand_found_in = b_cand;
         free_found_in = b_free;
         // lowest live id opens the run, first dead slot after it closes it
         if (!b_lo && step.live) begin
            lo_in  = 1'b1;
            run_in = 1'b1;
         end else if (b_run && !step.live) begin
            run_in        = 1'b0;
            cand_found_in = 1'b1;
            cand_in       = step_idx;
         end
         if (!step.live && !b_free) begin
            free_found_in = 1'b1;
            free_in       = step_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_ff         <= 1'b0;
         run_ff        <= 1'b0;
         cand_found_ff <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         lo_ff         <= lo_in;
         run_ff        <= run_in;
         cand_found_ff <= cand_found_in;
         free_found_ff <= free_found_in;
      end
      cand_ff <= cand_in;
      free_ff <= free_in;
   end

   // empty table takes id 0, a run reaching the top falls back to the lowest free id
   assign pick_full = lo_ff && !cand_found_ff && !free_found_ff;
   assign pick_id   = !lo_ff ? '0 : (cand_found_ff ? cand_ff : free_ff);

endmodule

[hdl/dtt_minscan.sv]
// expiry compare and running minimum of surviving deadlines
`timescale 1ns / 1ps

module dtt_minscan (
   input  logic                       clock,
   input  logic                       reset,
   input  dtt_pkg::scan_step_type     step,
   input  logic                       tick_mode,
   input  logic [dtt_pkg::TIME_W-1:0] now,
   input  logic [dtt_pkg::TIME_W-1:0] rd_deadline,
   output logic                       expire,
   output logic                       min_any,
   output logic [dtt_pkg::TIME_W-1:0] min_deadline
);
   import dtt_pkg::*;

   logic              min_any_ff, min_any_in;
   logic [TIME_W-1:0] min_ff, min_in;
   logic              keep;
   logic              base_any;

   always_comb begin
      expire     = step.valid && step.live && tick_mode && (rd_deadline <= now);
      keep       = step.valid && step.live && !expire;
      base_any   = step.first ? 1'b0 : min_any_ff;
      min_any_in = min_any_ff;
      min_in     = min_ff;
      if (step.valid) begin
         min_any_in = base_any;
         if (keep && (!base_any || (rd_deadline < min_ff))) begin
            min_any_in = 1'b1;
            min_in     = rd_deadline;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_any_ff <= 1'b0;
      end else begin
         min_any_ff <= min_any_in;
      end
      min_ff <= min_in;
   end

   assign min_any      = min_any_ff;
   assign min_deadline = min_ff;

endmodule
